@@ hdl/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared types, register map, reset values and fixed-point helpers for the
// escape-time iteration block.
// ----------------------------------------------------------------------------
package mbe_pkg;

   // Fixed widths of the register and field formats.
   localparam int VAL_W     = 32;
   localparam int PROD_W    = 64;
   localparam int SUM_W     = 66;
   localparam int CNT_W     = 12;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W = 3;

   // Register indexes (byte address is four times the index).
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_RE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_IM = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_STEP_RE   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_STEP_IM   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ITER_LIM  = 3'd4;

   // Reset values: a view of -2.0 - 1.5i with about 0.00073 per pixel.
   localparam logic signed [VAL_W-1:0] RST_ORIGIN_RE = -32'sd268435456;
   localparam logic signed [VAL_W-1:0] RST_ORIGIN_IM = -32'sd201326592;
   localparam logic signed [VAL_W-1:0] RST_STEP_RE   = 32'sd98332;
   localparam logic signed [VAL_W-1:0] RST_STEP_IM   = 32'sd98332;
   localparam logic [CNT_W-1:0]        RST_ITER_LIM  = 12'd1000;

   // Saturation bounds in the wide sum format.
   localparam logic signed [SUM_W-1:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [SUM_W-1:0] SAT_MIN = -66'sd2147483648;

   // Configuration registers as seen by the core.
   typedef struct packed {
      logic signed [VAL_W-1:0] origin_re;
      logic signed [VAL_W-1:0] origin_im;
      logic signed [VAL_W-1:0] step_re;
      logic signed [VAL_W-1:0] step_im;
      logic [CNT_W-1:0]        iteration_limit;
   } cfg_type;

   // Sequencer states of the core.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_RE,
      ST_LOAD_IM,
      ST_LOAD_END,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Clamp a wide signed sum to the 32-bit range.
   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[VAL_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[VAL_W-1:0];
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

   // Sign-extend a 32-bit value to the sum format.
   function automatic logic signed [SUM_W-1:0] ext_val(input logic signed [VAL_W-1:0] v);
      return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
   endfunction

   // Sign-extend a 64-bit product to the sum format.
   function automatic logic signed [SUM_W-1:0] ext_prod(input logic signed [PROD_W-1:0] v);
      return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
   endfunction

endpackage

@@ hdl/mbe_regs.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time register file
// APB-style configuration registers holding the view origin, the per-pixel
// step and the iteration limit.
// ----------------------------------------------------------------------------
module mbe_regs
   import mbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ORIGIN_RE: cfg_in.origin_re = csr_pwdata;
            REG_ORIGIN_IM: cfg_in.origin_im = csr_pwdata;
            REG_STEP_RE:   cfg_in.step_re = csr_pwdata;
            REG_STEP_IM:   cfg_in.step_im = csr_pwdata;
            REG_ITER_LIM:  cfg_in.iteration_limit = csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (reg_idx)
         REG_ORIGIN_RE: csr_prdata = cfg_ff.origin_re;
         REG_ORIGIN_IM: csr_prdata = cfg_ff.origin_im;
         REG_STEP_RE:   csr_prdata = cfg_ff.step_re;
         REG_STEP_IM:   csr_prdata = cfg_ff.step_im;
         REG_ITER_LIM:  csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, cfg_ff.iteration_limit};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_re       <= RST_ORIGIN_RE;
         cfg_ff.origin_im       <= RST_ORIGIN_IM;
         cfg_ff.step_re         <= RST_STEP_RE;
         cfg_ff.step_im         <= RST_STEP_IM;
         cfg_ff.iteration_limit <= RST_ITER_LIM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/mbe_core.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core
// Sequencer around one shared 32x32 signed multiplier. It forms the point c,
// then runs z = z^2 + c with an escape test in square, cross and update steps.
// ----------------------------------------------------------------------------
module mbe_core
   import mbe_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 27
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_column,
   input  logic [COORD_BITS-1:0] req_row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CNT_W-1:0]      rsp_escape_count
);

   // Escape threshold 4.0 (radius 2.0 squared) in the product format.
   localparam int         THR_SHIFT  = 2 * FRAC_BITS + 2;
   localparam logic       CAN_ESCAPE = (THR_SHIFT < PROD_W);
   localparam logic [PROD_W:0] THRESH = CAN_ESCAPE ? ((PROD_W+1)'(1) << THR_SHIFT) : '0;

   state_type state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [CNT_W-1:0]      it_ff, it_in;
   logic [CNT_W-1:0]      res_ff, res_in;
   logic signed [VAL_W-1:0]  cre_ff, cre_in;
   logic signed [VAL_W-1:0]  cim_ff, cim_in;
   logic signed [VAL_W-1:0]  zr_ff, zr_in;
   logic signed [VAL_W-1:0]  zi_ff, zi_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] sr_ff, sr_in;
   logic signed [PROD_W-1:0] diff_ff, diff_in;

   logic signed [VAL_W-1:0]  mul_a;
   logic signed [VAL_W-1:0]  mul_b;
   logic signed [VAL_W-1:0]  col_ext;
   logic signed [VAL_W-1:0]  row_ext;
   logic signed [VAL_W-1:0]  cim_sat;
   logic [PROD_W:0]          mag;
   logic                     escaped;

   assign col_ext = {{(VAL_W-COORD_BITS){1'b0}}, col_ff};
   assign row_ext = {{(VAL_W-COORD_BITS){1'b0}}, row_ff};
   assign cim_sat = sat32(ext_val(cfg.origin_im) + ext_prod(prod_ff));

   // Squared magnitude of the current z; both squares are non-negative.
   assign mag     = {1'b0, sr_ff} + {1'b0, prod_ff};
   assign escaped = CAN_ESCAPE && (it_ff != '0) && (mag > THRESH);

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_count_ff;

   // Operand select for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_LOAD_RE: begin
            mul_a = cfg.step_re;
            mul_b = col_ext;
         end
         ST_LOAD_IM: begin
            mul_a = cfg.step_im;
            mul_b = row_ext;
         end
         ST_SQ_RE: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         ST_SQ_IM: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      limit_in     = limit_ff;
      it_in        = it_ff;
      res_in       = res_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      prod_in      = mul_a * mul_b;
      sr_in        = sr_ff;
      diff_in      = diff_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               col_in   = req_column;
               row_in   = req_row;
               limit_in = cfg.iteration_limit;
               state_in = ST_LOAD_RE;
            end
         end
         ST_LOAD_RE: begin
            state_in = ST_LOAD_IM;
         end
         ST_LOAD_IM: begin
            cre_in   = sat32(ext_val(cfg.origin_re) + ext_prod(prod_ff));
            state_in = ST_LOAD_END;
         end
         ST_LOAD_END: begin
            cim_in   = cim_sat;
            zr_in    = cre_ff;
            zi_in    = cim_sat;
            it_in    = '0;
            state_in = ST_SQ_RE;
         end
         ST_SQ_RE: begin
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            sr_in    = prod_ff;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            // The squares of this z test the escape of the previous iteration.
            if (escaped) begin
               res_in   = it_ff - 1'b1;
               state_in = ST_FINISH;
            end else if (it_ff == limit_ff) begin
               res_in   = it_ff;
               state_in = ST_FINISH;
            end else begin
               diff_in  = sr_ff - prod_ff;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            zr_in    = sat32(ext_prod(diff_ff >>> FRAC_BITS) + ext_val(cre_ff));
            zi_in    = sat32(ext_prod(prod_ff >>> (FRAC_BITS - 1)) + ext_val(cim_ff));
            it_in    = it_ff + 1'b1;
            state_in = ST_SQ_RE;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      limit_ff     <= limit_in;
      it_ff        <= it_in;
      res_ff       <= res_in;
      cre_ff       <= cre_in;
      cim_ff       <= cim_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      prod_ff      <= prod_in;
      sr_ff        <= sr_in;
      diff_ff      <= diff_in;
   end

   // The iteration counter never runs past the limit taken with the item.
   a_it_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_RE || state_ff == ST_SQ_IM || state_ff == ST_CROSS ||
       state_ff == ST_UPDATE) |-> it_ff <= limit_ff)
      else $error("iteration counter beyond limit");

   // An iteration step is only entered below the limit.
   a_update_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> it_ff < limit_ff)
      else $error("update step at the limit");

   // A result appears only out of the finish step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result without finish");

   // An accepted item starts the point computation.
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_LOAD_RE)
      else $error("accepted item did not start");

endmodule

@@ hdl/mandelbrot_escape_time_top.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time top level
// Escape-time iteration for one pixel at a time with APB-style configuration.
// ----------------------------------------------------------------------------
// Usage:
// An item on the req_ channel carries a pixel column and row. The block forms
// c = origin + step * coordinate per axis in signed fixed point with
// FRAC_BITS fraction bits, iterates z = z^2 + c from z = c and returns on
// the rsp_ channel the 0-based iteration at which |z|^2 first exceeds 4, or
// the iteration limit when z stays bounded.
// Sequence: all products go through one 32x32 multiplier. The point is
// formed in the load steps; each iteration runs the two squares, the cross
// product and the update; the final escape test runs the two squares and
// the cross step, and the finish step hands the result off. The block takes
// one item at a time; req_ready is high only while it is idle.
// The result sits in an output register, so a new item may be accepted while
// the receiver stalls; a finished item waits in its last step until the
// output register is free. Reset clears the sequencer and the output valid
// and loads the default view and a limit of 1000. Registers lie at byte
// addresses 0 to 16. The user must write them only while the block is idle;
// the block itself has no check for it.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top
   import mbe_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 27
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_column,
   input  logic [COORD_BITS-1:0] req_row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CNT_W-1:0]      rsp_escape_count,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   // Configuration registers.
   mbe_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Iteration core.
   mbe_core #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_column       (req_column),
      .req_row          (req_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_escape_count (rsp_escape_count)
   );

endmodule
